### rtl/apt_pkg.sv
package apt_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int FIELD_W     = 32;
	localparam int IDX_W       = 4;
	localparam int ENTRY_COUNT = 12;
	localparam int S_TDATA_W   = 136;
	localparam int M_TDATA_W   = 96;

	// entry positions, row*3 + column
	localparam int ROW_X = 0;
	localparam int ROW_Y = 3;
	localparam int ROW_Z = 6;
	localparam int ROW_T = 9;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} opcode_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} apt_ctl_t;

endpackage

### rtl/apt_column.sv
module apt_column #(
	parameter int DATA_W    = apt_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  apt_pkg::apt_ctl_t        ctl,
	input  logic signed [DATA_W-1:0] px,
	input  logic signed [DATA_W-1:0] py,
	input  logic signed [DATA_W-1:0] pz,
	input  logic signed [DATA_W-1:0] mx,
	input  logic signed [DATA_W-1:0] my,
	input  logic signed [DATA_W-1:0] mz,
	input  logic signed [DATA_W-1:0] mt,
	output logic signed [DATA_W-1:0] value,
	output logic                     ovf
);

	localparam int PROD_W = 2 * DATA_W;
	localparam int WIDE_W = (PROD_W > DATA_W + FRAC_BITS) ? PROD_W : DATA_W + FRAC_BITS;
	localparam int SUM_W  = WIDE_W + 2;
	localparam int SH_W   = SUM_W - FRAC_BITS;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [DATA_W-1:0] trans_s1;
	logic signed [SUM_W-1:0]  sum;
	logic        [SH_W-1:0]   shifted;
	logic                     fits;
	logic signed [DATA_W-1:0] value_s2;
	logic                     ovf_s2;

	// products of this column
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			prod_x_s1 <= PROD_W'(px) * PROD_W'(mx);
			prod_y_s1 <= PROD_W'(py) * PROD_W'(my);
			prod_z_s1 <= PROD_W'(pz) * PROD_W'(mz);
			trans_s1  <= mt;
		end
	end

	always_comb begin
		sum = SUM_W'(prod_x_s1) + SUM_W'(prod_y_s1) + SUM_W'(prod_z_s1)
			+ (SUM_W'(trans_s1) <<< FRAC_BITS);
		shifted = sum[SUM_W-1:FRAC_BITS];
		fits = (&shifted[SH_W-1:DATA_W-1]) | ~(|shifted[SH_W-1:DATA_W-1]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			value_s2 <= fits ? shifted[DATA_W-1:0] : (shifted[SH_W-1] ? SAT_MIN : SAT_MAX);
			ovf_s2   <= ~fits;
		end
	end

	assign value = value_s2;
	assign ovf   = ovf_s2;

endmodule

### rtl/affine_point_transform.sv
// channel  | dir | tdata fields (low bit up)                       | tuser
// s_axis   | in  | entry_index 4, entry_value 32, x, y, z 32, pad 4 | opcode
// m_axis   | out | out_x, out_y, out_z 32                           | overflow
//
// one word a cycle on each side while m_axis_tready does not stall the output; a transform
// shows on m_axis after it passes the product register and then the sum/saturate result register
// load words write the matrix at the edge they are taken and give no output
// reset clears both valid flags and sets the matrix to identity, zero translation
// s_axis stays ready while a result waits, as long as the product stage is empty
module affine_point_transform #(
	parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = apt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// entry_index, entry_value, point_x, point_y, point_z, zero pad
	input  logic [apt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// opcode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_x, out_y, out_z
	output logic [apt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// overflow
	output logic                          m_axis_tuser
);

	localparam int DATA_W = (VALUE_WIDTH < apt_pkg::FIELD_W) ? VALUE_WIDTH : apt_pkg::FIELD_W;
	localparam int FW     = apt_pkg::FIELD_W;
	localparam int IW     = apt_pkg::IDX_W;

	localparam logic signed [DATA_W-1:0] ONE_VAL = (FRAC_BITS < DATA_W - 1)
		? (DATA_W'(1) << FRAC_BITS) : {1'b0, {(DATA_W-1){1'b1}}};

	logic signed [DATA_W-1:0] matrix_q [apt_pkg::ENTRY_COUNT];

	logic [IW-1:0]            entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] px, py, pz;
	apt_pkg::opcode_t         opcode;

	logic              vld_s1, vld_s2;
	logic              out_free;
	logic              take;
	apt_pkg::apt_ctl_t ctl;

	logic signed [DATA_W-1:0] res_x, res_y, res_z;
	logic                     ovf_x, ovf_y, ovf_z;

	assign entry_index = s_axis_tdata[IW-1:0];
	assign entry_value = s_axis_tdata[IW +: DATA_W];
	assign px          = s_axis_tdata[IW + FW +: DATA_W];
	assign py          = s_axis_tdata[IW + 2*FW +: DATA_W];
	assign pz          = s_axis_tdata[IW + 3*FW +: DATA_W];
	assign opcode      = apt_pkg::opcode_t'(s_axis_tuser);

	assign out_free      = ~vld_s2 | m_axis_tready;
	assign s_axis_tready = ~vld_s1 | out_free;
	assign take          = s_axis_tvalid & s_axis_tready;

	assign ctl.load_s1 = take & (opcode == apt_pkg::OP_XFORM);
	assign ctl.load_s2 = vld_s1 & out_free;

	// matrix store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < apt_pkg::ENTRY_COUNT; k++) begin
				matrix_q[k] <= (k == 0 || k == 4 || k == 8) ? ONE_VAL : '0;
			end
		end else if (take && opcode == apt_pkg::OP_LOAD
				&& entry_index < IW'(apt_pkg::ENTRY_COUNT)) begin
			matrix_q[entry_index] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= ctl.load_s1;
			end
			if (out_free) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	apt_column #(.DATA_W(DATA_W), .FRAC_BITS(FRAC_BITS)) u_col_x (
		.clk   (clk),
		.ctl   (ctl),
		.px    (px),
		.py    (py),
		.pz    (pz),
		.mx    (matrix_q[apt_pkg::ROW_X]),
		.my    (matrix_q[apt_pkg::ROW_Y]),
		.mz    (matrix_q[apt_pkg::ROW_Z]),
		.mt    (matrix_q[apt_pkg::ROW_T]),
		.value (res_x),
		.ovf   (ovf_x)
	);

	apt_column #(.DATA_W(DATA_W), .FRAC_BITS(FRAC_BITS)) u_col_y (
		.clk   (clk),
		.ctl   (ctl),
		.px    (px),
		.py    (py),
		.pz    (pz),
		.mx    (matrix_q[apt_pkg::ROW_X + 1]),
		.my    (matrix_q[apt_pkg::ROW_Y + 1]),
		.mz    (matrix_q[apt_pkg::ROW_Z + 1]),
		.mt    (matrix_q[apt_pkg::ROW_T + 1]),
		.value (res_y),
		.ovf   (ovf_y)
	);

	apt_column #(.DATA_W(DATA_W), .FRAC_BITS(FRAC_BITS)) u_col_z (
		.clk   (clk),
		.ctl   (ctl),
		.px    (px),
		.py    (py),
		.pz    (pz),
		.mx    (matrix_q[apt_pkg::ROW_X + 2]),
		.my    (matrix_q[apt_pkg::ROW_Y + 2]),
		.mz    (matrix_q[apt_pkg::ROW_Z + 2]),
		.mt    (matrix_q[apt_pkg::ROW_T + 2]),
		.value (res_z),
		.ovf   (ovf_z)
	);

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {FW'(res_z), FW'(res_y), FW'(res_x)};
	assign m_axis_tuser  = ovf_x | ovf_y | ovf_z;

endmodule
